[rtl/dss_pkg.sv]
// Package for the dual stack shared buffer: sizes, field types, codes and the
// command and status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package dss_pkg;

    localparam int Depth    = 32;
    localparam int AddrW    = $clog2(Depth);
    localparam int CntW     = $clog2(Depth + 1);
    localparam int DataW    = 32;

    localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

    localparam logic [2:0] OP_PUSH_A  = 3'd0;
    localparam logic [2:0] OP_PUSH_B  = 3'd1;
    localparam logic [2:0] OP_POP_A   = 3'd2;
    localparam logic [2:0] OP_POP_B   = 3'd3;
    localparam logic [2:0] OP_CLEAR_A = 3'd4;
    localparam logic [2:0] OP_CLEAR_B = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]              op;
        logic signed [DataW-1:0] push_value;
    } t_in;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [DataW-1:0] popped_value;
        logic                    last;
    } t_out;

    typedef struct packed {
        logic       wr_a;
        logic       wr_b;
        logic       rd_a;
        logic       rd_b;
        logic       out_load;
        logic [1:0] out_status;
        logic       out_use_ram;
        logic       out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic a_empty;
        logic b_empty;
        logic full;
        logic a_one;
        logic b_one;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/dss_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module dss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds its value until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/dss_datapath.sv]
// Datapath: stack pointers, the shared slot RAM and the output register.
// Depends on dss_pkg and dss_ram.
`default_nettype none

module dss_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dss_pkg::t_dp_cmd              i_cmd,
    input  wire logic signed [dss_pkg::DataW-1:0] i_push_value,
    input  wire logic                          i_out_ready,
    output dss_pkg::t_dp_stat                  o_stat,
    output logic                               o_out_valid,
    output dss_pkg::t_out                      o_out_data
);

    logic [dss_pkg::CntW-1:0]  r_count_a, n_count_a;
    logic [dss_pkg::CntW-1:0]  r_start_b, n_start_b;
    logic                      r_out_valid;
    dss_pkg::t_out             r_out_data;

    logic [dss_pkg::CntW-1:0]  a_top;
    logic [dss_pkg::CntW-1:0]  b_below;
    logic                      ram_we;
    logic [dss_pkg::AddrW-1:0] ram_waddr;
    logic                      ram_re;
    logic [dss_pkg::AddrW-1:0] ram_raddr;
    logic [dss_pkg::DataW-1:0] ram_rdata;

    assign a_top   = r_count_a - dss_pkg::CntW'(1);
    assign b_below = r_start_b - dss_pkg::CntW'(1);

    assign ram_we    = i_cmd.wr_a || i_cmd.wr_b;
    assign ram_waddr = i_cmd.wr_b ? b_below[dss_pkg::AddrW-1:0]
                                  : r_count_a[dss_pkg::AddrW-1:0];
    assign ram_re    = i_cmd.rd_a || i_cmd.rd_b;
    assign ram_raddr = i_cmd.rd_b ? r_start_b[dss_pkg::AddrW-1:0]
                                  : a_top[dss_pkg::AddrW-1:0];

    dss_ram #(
        .WIDTH (dss_pkg::DataW),
        .DEPTH (dss_pkg::Depth)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_push_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_count_a = r_count_a;
        n_start_b = r_start_b;
        if (i_cmd.wr_a) begin
            n_count_a = r_count_a + dss_pkg::CntW'(1);
        end
        if (i_cmd.rd_a) begin
            n_count_a = a_top;
        end
        if (i_cmd.wr_b) begin
            n_start_b = b_below;
        end
        if (i_cmd.rd_b) begin
            n_start_b = r_start_b + dss_pkg::CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_a   <= '0;
            r_start_b   <= dss_pkg::DepthCnt;
            r_out_valid <= 1'b0;
        end else begin
            r_count_a <= n_count_a;
            r_start_b <= n_start_b;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.status       <= i_cmd.out_status;
            r_out_data.popped_value <= i_cmd.out_use_ram ? ram_rdata : '0;
            r_out_data.last         <= i_cmd.out_last;
        end
    end

    assign o_stat.a_empty  = (r_count_a == '0);
    assign o_stat.b_empty  = (r_start_b == dss_pkg::DepthCnt);
    assign o_stat.full     = (r_count_a == r_start_b);
    assign o_stat.a_one    = (r_count_a == dss_pkg::CntW'(1));
    assign o_stat.b_one    = (r_start_b == dss_pkg::DepthCnt - dss_pkg::CntW'(1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_stacks_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count_a <= r_start_b) && (r_start_b <= dss_pkg::DepthCnt))
        else $error("stack pointers crossed or left the buffer");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten before its transaction");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_a || i_cmd.wr_b) |-> (r_count_a != r_start_b))
        else $error("push written into a full buffer");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.rd_a && (r_count_a == '0)) &&
        !(i_cmd.rd_b && (r_start_b == dss_pkg::DepthCnt)))
        else $error("read issued on an empty stack");
`endif

endmodule

`default_nettype wire

[rtl/dss_ctrl.sv]
// Controller state machine: decodes each transaction and sequences the
// slot reads for pops and clears. Depends on dss_pkg.
`default_nettype none

module dss_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [2:0]        i_op,
    input  wire dss_pkg::t_dp_stat i_stat,
    output logic                   o_in_ready,
    output dss_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_sel_b, n_sel_b;
    logic   r_clear, n_clear;
    logic   r_last,  n_last;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_sel_b = r_sel_b;
        n_clear = r_clear;
        n_last  = r_last;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        dss_pkg::OP_PUSH_A, dss_pkg::OP_PUSH_B: begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_status = dss_pkg::ST_FULL;
                            end else begin
                                o_cmd.out_status = dss_pkg::ST_OK;
                                o_cmd.wr_a = (i_op == dss_pkg::OP_PUSH_A);
                                o_cmd.wr_b = (i_op == dss_pkg::OP_PUSH_B);
                            end
                        end
                        dss_pkg::OP_POP_A, dss_pkg::OP_CLEAR_A: begin
                            if (i_stat.a_empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = dss_pkg::ST_EMPTY;
                                o_cmd.out_last   = 1'b1;
                            end else begin
                                n_sel_b = 1'b0;
                                n_clear = (i_op == dss_pkg::OP_CLEAR_A);
                                n_state = S_ISSUE;
                            end
                        end
                        dss_pkg::OP_POP_B, dss_pkg::OP_CLEAR_B: begin
                            if (i_stat.b_empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = dss_pkg::ST_EMPTY;
                                o_cmd.out_last   = 1'b1;
                            end else begin
                                n_sel_b = 1'b1;
                                n_clear = (i_op == dss_pkg::OP_CLEAR_B);
                                n_state = S_ISSUE;
                            end
                        end
                        default: begin
                            // Unused codes are taken and dropped.
                        end
                    endcase
                end
            end
            S_ISSUE: begin
                o_cmd.rd_a = !r_sel_b;
                o_cmd.rd_b = r_sel_b;
                n_last  = !r_clear || (r_sel_b ? i_stat.b_one : i_stat.a_one);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_status  = dss_pkg::ST_OK;
                    o_cmd.out_use_ram = 1'b1;
                    o_cmd.out_last    = r_last;
                    n_state = r_last ? S_IDLE : S_ISSUE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel_b <= 1'b0;
            r_clear <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel_b <= n_sel_b;
            r_clear <= n_clear;
            r_last  <= n_last;
        end
    end

`ifndef SYNTHESIS
    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register lost its one-hot code");

    a_issue_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |=> (r_state == S_EMIT))
        else $error("slot read not followed by its result");

    a_single_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ISSUE) && !r_clear) |=> r_last)
        else $error("single pop not marked as final result");
`endif

endmodule

`default_nettype wire

[rtl/dual_stack_shared_buffer_unit.sv]
// Two stacks in one shared 32-slot buffer: A grows up from slot 0, B down from the top.
// Push, and any operation on an empty stack, loads its result at the accepting edge, so it
// is offered in the next cycle; a new transaction may follow every cycle while results are taken.
// Pop: accept, slot read and result, each in its own state; a clear repeats the slot read and
// the result for every element, as every element needs its own registered read of the slot RAM.
// Synchronous active-low reset clears the pointers, the state machine and output valid;
// slot contents are undefined until written and get no clearing pass.
// Depends on dss_pkg, dss_ctrl and dss_datapath.
`default_nettype none

module dual_stack_shared_buffer_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire dss_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output dss_pkg::t_out      o_out_data
);

    // The controller owns sequencing only; the datapath owns the pointers,
    // the slot RAM and the output register. They talk through two structs.
    dss_pkg::t_dp_cmd  dp_cmd;
    dss_pkg::t_dp_stat dp_stat;

    // An input transaction is taken only when the controller is idle and the
    // output register is free or being emptied in the same cycle, so a
    // result that loads straight away can never overwrite a waiting one.
    dss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.op),
        .i_stat     (dp_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd)
    );

    // Pops and clears read the top slot into the registered RAM output, which the output
    // register takes once it is free; the pointer moves with the read.
    dss_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_push_value (i_in_data.push_value),
        .i_out_ready  (i_out_ready),
        .o_stat       (dp_stat),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for dual_stack_shared_buffer_unit: a directed table, then random
// traffic in bursts, with every output transaction checked against a fixed row result or an in-bench stack predictor.
// Depends on dss_pkg and the RTL of the unit.

module tb;
    import dss_pkg::*;

    // The two op codes that the unit must swallow without any result.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int CycleLimit      = 1_000_000;
    localparam int HoldOff         = 300;
    localparam int TailCycles      = 80;
    localparam int ShownMismatches = 10;

    // One line of the directed table. Where typed is set, fixed_res is the single result
    // that the operation must give; otherwise the predictor supplies the expectation.
    typedef struct packed {
        t_in  item;
        logic typed;
        t_out fixed_res;
    } t_row;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    dual_stack_shared_buffer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Predictor state: a mirror of the slot RAM, the fill level of stack A and the lowest
    // slot held by stack B (equal to the depth while B is empty).
    logic [DataW-1:0] slot_mirror [Depth];
    logic [CntW-1:0]  a_fill;
    logic [CntW-1:0]  b_base;

    t_out op_results [$];   // results of the operation just accepted
    t_out awaited_out [$];  // output transactions still to arrive, oldest first
    t_row directed_rows [$];
    logic [2:0] op_menu [6];

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic stall_req   = 1'b0;
    logic stall_seen  = 1'b0;
    int   stall_left  = 0;

    int   fail_count      = 0;
    int   accepted_ops    = 0;
    int   results_checked = 0;
    int   full_seen       = 0;
    int   empty_seen      = 0;
    t_out front_res;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_out result_of(input logic [1:0] status, input logic [DataW-1:0] value,
                                       input logic is_last);
        t_out r;
        r.status       = status;
        r.popped_value = value;
        r.last         = is_last;
        return r;
    endfunction

    function automatic t_row stim_row(input logic [2:0] op, input logic [DataW-1:0] value,
                                      input logic typed, input logic [1:0] status,
                                      input logic [DataW-1:0] popped, input logic is_last);
        t_row r;
        r.item.op         = op;
        r.item.push_value = value;
        r.typed           = typed;
        r.fixed_res       = result_of(status, popped, is_last);
        return r;
    endfunction

    // Works out the results of one accepted operation and advances the predictor state.
    function automatic void apply_stack_op(input t_in item);
        op_results.delete();
        case (item.op)
            OP_PUSH_A: begin
                // The buffer is full when the two stacks meet, whichever of them is empty.
                if (a_fill >= b_base) begin
                    op_results.push_back(result_of(ST_FULL, '0, 1'b1));
                end else begin
                    slot_mirror[a_fill[AddrW-1:0]] = item.push_value;
                    a_fill = a_fill + 1'b1;
                    op_results.push_back(result_of(ST_OK, '0, 1'b1));
                end
            end
            OP_PUSH_B: begin
                if (b_base <= a_fill) begin
                    op_results.push_back(result_of(ST_FULL, '0, 1'b1));
                end else begin
                    b_base = b_base - 1'b1;
                    slot_mirror[b_base[AddrW-1:0]] = item.push_value;
                    op_results.push_back(result_of(ST_OK, '0, 1'b1));
                end
            end
            OP_POP_A: begin
                if (a_fill == '0) begin
                    op_results.push_back(result_of(ST_EMPTY, '0, 1'b1));
                end else begin
                    a_fill = a_fill - 1'b1;
                    op_results.push_back(result_of(ST_OK, slot_mirror[a_fill[AddrW-1:0]], 1'b1));
                end
            end
            OP_POP_B: begin
                if (b_base == DepthCnt) begin
                    op_results.push_back(result_of(ST_EMPTY, '0, 1'b1));
                end else begin
                    op_results.push_back(result_of(ST_OK, slot_mirror[b_base[AddrW-1:0]], 1'b1));
                    b_base = b_base + 1'b1;
                end
            end
            OP_CLEAR_A: begin
                if (a_fill == '0) begin
                    op_results.push_back(result_of(ST_EMPTY, '0, 1'b1));
                end
                // Elements leave from the top down; the one in slot 0 carries the last flag.
                while (a_fill != '0) begin
                    a_fill = a_fill - 1'b1;
                    op_results.push_back(result_of(ST_OK, slot_mirror[a_fill[AddrW-1:0]],
                                                   a_fill == '0));
                end
            end
            OP_CLEAR_B: begin
                if (b_base == DepthCnt) begin
                    op_results.push_back(result_of(ST_EMPTY, '0, 1'b1));
                end
                while (b_base != DepthCnt) begin
                    op_results.push_back(result_of(ST_OK, slot_mirror[b_base[AddrW-1:0]],
                                                   b_base == DepthCnt - 1));
                    b_base = b_base + 1'b1;
                end
            end
            default: begin
                // Spare op codes: no result and no change of state.
            end
        endcase
    endfunction

    function automatic void report_mismatch(input string what, input t_out want, input t_out got);
        fail_count++;
        if (fail_count <= ShownMismatches) begin
            $display("%0t %s: expected status %0d value %h last %b, got status %0d value %h last %b",
                     $time, what, want.status, want.popped_value, want.last,
                     got.status, got.popped_value, got.last);
        end
    endfunction

    // Offers one input transaction, holding valid and the payload steady until it is taken.
    // The sender may idle first; valid is only lowered in a step where it is not raised.
    task automatic offer_op(input t_in item, input logic typed, input t_out fixed_res);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        apply_stack_op(item);
        if (typed) begin
            awaited_out.push_back(fixed_res);
        end else begin
            foreach (op_results[k]) awaited_out.push_back(op_results[k]);
        end
        accepted_ops++;
    endtask

    // The sender stops offering until every awaited result has been taken.
    task automatic settle_outputs();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_out.size() != 0);
    endtask

    // Random traffic in bursts: long push runs so that the stacks meet and refuse pushes,
    // pop runs that empty them, clears, and mixed stretches that carry the spare op codes
    // as noise. Spare codes are not counted towards n_items.
    task automatic run_random(input int n_items, input logic with_holdoff);
        int         done;
        int         burst_left;
        int         pick;
        logic       mixed;
        logic [2:0] burst_op;
        t_in        item;
        done       = 0;
        burst_left = 0;
        mixed      = 1'b0;
        burst_op   = OP_PUSH_A;
        while (done < n_items) begin
            if (burst_left == 0) begin
                pick  = $urandom_range(0, 9);
                mixed = 1'b0;
                if (pick < 4) begin
                    burst_op   = $urandom_range(0, 1) ? OP_PUSH_B : OP_PUSH_A;
                    burst_left = $urandom_range(1, 40);
                end else if (pick < 6) begin
                    burst_op   = $urandom_range(0, 1) ? OP_POP_B : OP_POP_A;
                    burst_left = $urandom_range(1, 12);
                end else if (pick < 7) begin
                    burst_op   = $urandom_range(0, 1) ? OP_CLEAR_B : OP_CLEAR_A;
                    burst_left = 1;
                end else begin
                    mixed      = 1'b1;
                    burst_left = $urandom_range(1, 12);
                end
            end
            burst_left--;
            item.push_value = $urandom;
            if (!mixed) begin
                item.op = burst_op;
            end else if ($urandom_range(0, 19) == 0) begin
                item.op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
            end else begin
                item.op = op_menu[$urandom_range(0, 5)];
            end
            offer_op(item, 1'b0, '0);
            if (item.op != OP_SPARE_6 && item.op != OP_SPARE_7) begin
                done++;
                // Ask the receiver for a long hold-off while the sender keeps offering,
                // so that the unit fills up and has to refuse its input.
                if (with_holdoff && done == 20) stall_req <= ~stall_req;
            end
        end
    endtask

    // Receiver: drives ready at random, holds ready low through a hold-off when asked, and checks
    // every accepted output transaction against the oldest awaited result.
    always @(posedge i_clk) begin
        if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            stall_left <= HoldOff;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
        i_out_ready <= (stall_req == stall_seen) && (stall_left == 0) &&
                       ($urandom_range(0, 99) >= rx_idle_pct);

        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (o_out_data.status == ST_FULL) full_seen++;
            if (o_out_data.status == ST_EMPTY) empty_seen++;
            if (awaited_out.size() == 0) begin
                report_mismatch("output with nothing awaited", '0, o_out_data);
            end else begin
                front_res = awaited_out.pop_front();
                if (front_res.status !== o_out_data.status ||
                    front_res.popped_value !== o_out_data.popped_value ||
                    front_res.last !== o_out_data.last) begin
                    report_mismatch("result mismatch", front_res, o_out_data);
                end
            end
        end
    end

    // Watchdog: a stuck handshake or a missing result ends the run here.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results still awaited.",
                 cycles, awaited_out.size());
        $display("tb NOT OK");
        $finish;
    end

    initial begin : main_flow
        int idx;
        a_fill  = '0;
        b_base  = DepthCnt;
        op_menu = '{OP_PUSH_A, OP_PUSH_B, OP_POP_A, OP_POP_B, OP_CLEAR_A, OP_CLEAR_B};

        // Directed table. Straight after reset both stacks are empty, so pops and clears
        // report empty; pushes into free space answer ok with a zero value.
        directed_rows.push_back(stim_row(OP_POP_A,   '0, 1'b1, ST_EMPTY, '0, 1'b1));
        directed_rows.push_back(stim_row(OP_POP_B,   '0, 1'b1, ST_EMPTY, '0, 1'b1));
        directed_rows.push_back(stim_row(OP_CLEAR_A, '0, 1'b1, ST_EMPTY, '0, 1'b1));
        directed_rows.push_back(stim_row(OP_CLEAR_B, '0, 1'b1, ST_EMPTY, '0, 1'b1));
        // Spare op codes give no transaction at all.
        directed_rows.push_back(stim_row(OP_SPARE_6, 32'h1234_5678, 1'b0, ST_OK, '0, 1'b0));
        directed_rows.push_back(stim_row(OP_SPARE_7, 32'hFFFF_FFFF, 1'b0, ST_OK, '0, 1'b0));
        // Extreme values on both stacks.
        directed_rows.push_back(stim_row(OP_PUSH_A, 32'h7FFF_FFFF, 1'b1, ST_OK, '0, 1'b1));
        directed_rows.push_back(stim_row(OP_PUSH_A, 32'h8000_0000, 1'b1, ST_OK, '0, 1'b1));
        directed_rows.push_back(stim_row(OP_PUSH_B, 32'hFFFF_FFFF, 1'b1, ST_OK, '0, 1'b1));
        directed_rows.push_back(stim_row(OP_PUSH_B, 32'h0000_0000, 1'b1, ST_OK, '0, 1'b1));
        directed_rows.push_back(stim_row(OP_POP_A,  '0, 1'b0, ST_OK, '0, 1'b0));
        directed_rows.push_back(stim_row(OP_POP_B,  '0, 1'b0, ST_OK, '0, 1'b0));
        directed_rows.push_back(stim_row(OP_POP_B,  '0, 1'b0, ST_OK, '0, 1'b0));
        directed_rows.push_back(stim_row(OP_POP_B,  '0, 1'b1, ST_EMPTY, '0, 1'b1));
        // Multi-element clears, with the last flag only on the final element.
        directed_rows.push_back(stim_row(OP_PUSH_A, 32'hAAAA_AAAA, 1'b0, ST_OK, '0, 1'b0));
        directed_rows.push_back(stim_row(OP_PUSH_A, 32'h5555_5555, 1'b0, ST_OK, '0, 1'b0));
        directed_rows.push_back(stim_row(OP_CLEAR_A, '0, 1'b0, ST_OK, '0, 1'b0));
        directed_rows.push_back(stim_row(OP_PUSH_B, 32'h0000_0001, 1'b0, ST_OK, '0, 1'b0));
        directed_rows.push_back(stim_row(OP_PUSH_B, 32'h8000_0000, 1'b0, ST_OK, '0, 1'b0));
        directed_rows.push_back(stim_row(OP_CLEAR_B, '0, 1'b0, ST_OK, '0, 1'b0));
        directed_rows.push_back(stim_row(OP_POP_A,   '0, 1'b1, ST_EMPTY, '0, 1'b1));
        directed_rows.push_back(stim_row(OP_CLEAR_B, '0, 1'b1, ST_EMPTY, '0, 1'b1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First phase: the sender idles a little, the receiver a lot.
        tx_idle_pct = 23;
        rx_idle_pct <= 78;
        for (idx = 0; idx < directed_rows.size(); idx++) begin
            offer_op(directed_rows[idx].item, directed_rows[idx].typed,
                     directed_rows[idx].fixed_res);
        end
        run_random(117, 1'b1);
        settle_outputs();

        // Second phase: the other way round.
        tx_idle_pct = 78;
        rx_idle_pct <= 23;
        run_random(117, 1'b0);
        settle_outputs();

        // Third phase: both sides run flat out, apart from the requested hold-off.
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        run_random(116, 1'b1);
        settle_outputs();

        // Any stray output from a late clear would show up within this tail.
        repeat (TailCycles) @(posedge i_clk);

        $display("Covered %0d accepted operations (%0d from the directed table), %0d results.",
                 accepted_ops, directed_rows.size(), results_checked);
        $display("Refused pushes seen: %0d, empty-stack reports seen: %0d, failures: %0d.",
                 full_seen, empty_seen, fail_count);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
